[rtl/core/plt_pkg.sv]
// Shared types, operation codes and sequencing constants for the position ledger table.
package plt_pkg;

    localparam int unsigned TICKERS_DEF = 1024;

    // item operation codes
    localparam logic [2:0] OP_PEND   = 3'd0;
    localparam logic [2:0] OP_FILL   = 3'd1;
    localparam logic [2:0] OP_MANUAL = 3'd2;
    localparam logic [2:0] OP_PROFIT = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;

    // order offsets
    localparam logic [1:0] OFF_OPEN     = 2'd0;
    localparam logic [1:0] OFF_CLOSE    = 2'd1;
    localparam logic [1:0] OFF_CLOSE_YD = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_UNKNOWN   = 2'd1;
    localparam logic [1:0] STS_SHORT_POS = 2'd2;
    localparam logic [1:0] STS_INVALID   = 2'd3;

    // datapath commands
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_CLEAR   = 4'd1;
    localparam logic [3:0] CMD_LATCH   = 4'd2;
    localparam logic [3:0] CMD_MOD     = 4'd3;
    localparam logic [3:0] CMD_READ    = 4'd4;
    localparam logic [3:0] CMD_APPLY   = 4'd5;
    localparam logic [3:0] CMD_MUL     = 4'd6;
    localparam logic [3:0] CMD_NUM     = 4'd7;
    localparam logic [3:0] CMD_DIVINIT = 4'd8;
    localparam logic [3:0] CMD_DIV     = 4'd9;
    localparam logic [3:0] CMD_COST    = 4'd10;
    localparam logic [3:0] CMD_P1      = 4'd11;
    localparam logic [3:0] CMD_PROFIT  = 4'd12;
    localparam logic [3:0] CMD_WRITE   = 4'd13;

    // multiplier operand pairs
    localparam logic [1:0] MSEL_HCOST  = 2'd0;  // old holdings * |cost|
    localparam logic [1:0] MSEL_QPRICE = 2'd1;  // fill qty * |price|
    localparam logic [1:0] MSEL_HSIZE  = 2'd2;  // holdings * contract size
    localparam logic [1:0] MSEL_PDIFF  = 2'd3;  // (holdings*size) * |price diff|

    localparam logic [5:0] MOD_LAST = 6'd9;
    localparam logic [5:0] MUL_LAST = 6'd4;
    localparam logic [5:0] DIV_LAST = 6'd40;

    typedef struct packed {
        logic [2:0]         op;
        logic [9:0]         ticker;
        logic               direction;
        logic [1:0]         offset;
        logic signed [31:0] quantity;
        logic signed [47:0] price;
        logic signed [47:0] ask_price;
    } t_item;

    typedef struct packed {
        logic [30:0]        held;
        logic [30:0]        yday;
        logic [30:0]        openw;
        logic [30:0]        closew;
        logic signed [48:0] cost;
        logic signed [63:0] profit;
    } t_rec;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] size;
        t_rec [1:0]         rec;
    } t_row;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] sel;
        logic [5:0] cnt;
        logic       side;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_div;
        logic need_long;
        logic need_short;
    } t_sts;

    typedef struct packed {
        logic [1:0]         status;
        logic               notify;
        logic [9:0]         ticker_out;
        logic               side;
        logic [30:0]        holdings_out;
        logic [30:0]        yesterday_out;
        logic [30:0]        open_pending_out;
        logic [30:0]        close_pending_out;
        logic signed [47:0] cost_out;
        logic signed [63:0] profit_out;
        logic               last;
    } t_res;

endpackage

[rtl/core/plt_if.sv]
// Valid/ready channel interfaces for ledger items and ledger results.
interface plt_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [9:0]         ticker;
    logic               direction;
    logic [1:0]         offset;
    logic signed [31:0] quantity;
    logic signed [47:0] price;
    logic signed [47:0] ask_price;

    modport source (output valid, op, ticker, direction, offset, quantity, price, ask_price,
                    input ready);
    modport sink   (input valid, op, ticker, direction, offset, quantity, price, ask_price,
                    output ready);
endinterface

interface plt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               notify;
    logic [9:0]         ticker_out;
    logic               side;
    logic [30:0]        holdings_out;
    logic [30:0]        yesterday_out;
    logic [30:0]        open_pending_out;
    logic [30:0]        close_pending_out;
    logic signed [47:0] cost_out;
    logic signed [63:0] profit_out;
    logic               last;

    modport source (output valid, status, notify, ticker_out, side, holdings_out,
                    yesterday_out, open_pending_out, close_pending_out, cost_out,
                    profit_out, last, input ready);
    modport sink   (input valid, status, notify, ticker_out, side, holdings_out,
                    yesterday_out, open_pending_out, close_pending_out, cost_out,
                    profit_out, last, output ready);
endinterface

[rtl/core/plt_dp.sv]
// Ledger datapath: row memory, record update, shared multiplier and radix-4 divider.
module plt_dp #(
    parameter int unsigned TICKERS = plt_pkg::TICKERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  plt_pkg::t_item i_item,
    input  plt_pkg::t_cmd  i_cmd,
    output plt_pkg::t_sts  o_sts,
    output plt_pkg::t_res  o_res
);
    import plt_pkg::*;

    localparam int unsigned   AW        = (TICKERS > 1) ? $clog2(TICKERS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TICKERS - 1);
    localparam logic [26:0]   TICK_THR  = 27'(TICKERS);

    function automatic logic [30:0] sat_cnt(input logic [30:0] cur,
                                             input logic signed [32:0] dlt);
        logic signed [34:0] sum;
        sum = $signed({4'b0, cur}) + 35'(dlt);
        if (sum < 0) begin
            return 31'd0;
        end else if (sum > 35'sd2147483647) begin
            return 31'h7FFF_FFFF;
        end
        return sum[30:0];
    endfunction

    t_row mem [TICKERS];

    logic [AW-1:0]      r_clr;
    t_row               r_rd;
    t_row               r_row;
    logic [2:0]         r_op;
    logic [9:0]         r_t;
    logic               r_dir;
    logic [1:0]         r_off;
    logic signed [31:0] r_q;
    logic signed [47:0] r_price;
    logic signed [47:0] r_ask;
    logic [1:0]         r_status;
    logic               r_notify;
    logic               r_need_div;
    logic               r_need_long;
    logic               r_need_short;
    logic               r_side;
    logic [30:0]        r_hold;
    logic [31:0]        r_dsr;
    logic [127:0]       r_acc;
    logic [63:0]        r_pp;
    logic [1:0]         r_pps;
    logic               r_neg;
    logic [63:0]        r_p1;
    logic signed [81:0] r_num;
    logic [81:0]        r_dvd;
    logic [31:0]        r_rem;
    logic [47:0]        r_quo;
    logic               r_dneg;

    logic [AW-1:0] addr;
    assign addr = AW'(r_t);

    // ticker reduction: restoring subtract of TICKERS << cnt
    logic [26:0] thr;
    logic        mod_ge;
    assign thr    = TICK_THR << i_cmd.cnt[3:0];
    assign mod_ge = {17'b0, r_t} >= thr;

    // record update for the simple ops
    t_row               a_row;
    t_rec               a_rec;
    logic               a_close;
    logic               a_side;
    logic [1:0]         a_status;
    logic               a_notify;
    logic               a_div;
    logic               a_long;
    logic               a_short;
    logic signed [32:0] pos_q;
    logic signed [32:0] neg_q;
    logic signed [33:0] m_chk;

    always_comb begin
        a_row    = r_rd;
        a_status = STS_OK;
        a_notify = 1'b0;
        a_div    = 1'b0;
        a_long   = 1'b0;
        a_short  = 1'b0;
        a_close  = r_off != OFF_OPEN;
        a_side   = (r_op == OP_MANUAL) ? r_dir : (r_dir ^ a_close);
        a_rec    = r_rd.rec[a_side];
        pos_q    = 33'(r_q);
        neg_q    = -pos_q;
        m_chk    = $signed({3'b0, a_rec.held}) - $signed({3'b0, a_rec.closew}) + 34'(r_q);
        unique case (r_op)
            OP_PEND: begin
                if (r_q != 0) begin
                    if (a_close) a_rec.closew = sat_cnt(a_rec.closew, pos_q);
                    else         a_rec.openw  = sat_cnt(a_rec.openw, pos_q);
                    a_row.valid = 1'b1;
                    a_notify    = 1'b1;
                end
            end
            OP_FILL: begin
                if (r_q > 0) begin
                    if (r_rd.size == 0) begin
                        a_status = STS_UNKNOWN;
                    end else begin
                        a_row.valid = 1'b1;
                        a_notify    = 1'b1;
                        if (a_close) begin
                            a_rec.closew = sat_cnt(a_rec.closew, neg_q);
                            a_rec.held   = sat_cnt(a_rec.held, neg_q);
                            if (r_off == OFF_CLOSE || r_off == OFF_CLOSE_YD) begin
                                a_rec.yday = ({1'b0, a_rec.yday} < r_q[31:0]) ? 31'd0
                                           : a_rec.yday - r_q[30:0];
                            end
                            if (a_rec.held < a_rec.yday) a_rec.yday = a_rec.held;
                            if (a_rec.held == 31'd0) begin
                                a_rec.cost   = '0;
                                a_rec.profit = '0;
                            end
                        end else begin
                            a_rec.openw = sat_cnt(a_rec.openw, neg_q);
                            a_rec.held  = sat_cnt(a_rec.held, pos_q);
                            a_div       = 1'b1;
                        end
                    end
                end
            end
            OP_MANUAL: begin
                if (r_q != 0) begin
                    a_row.valid = 1'b1;
                    if (r_q < 0 && m_chk < 0) begin
                        a_status = STS_SHORT_POS;
                    end else begin
                        a_rec.held = sat_cnt(a_rec.held, pos_q);
                        a_notify   = 1'b1;
                    end
                end
            end
            OP_PROFIT: begin
                if (r_rd.valid && (r_rd.rec[0].held != 31'd0 || r_rd.rec[1].held != 31'd0)) begin
                    if (r_rd.size <= 0) begin
                        a_status = STS_INVALID;
                    end else begin
                        a_notify = 1'b1;
                        a_long   = (r_rd.rec[0].held != 31'd0) && (r_ask > 0);
                        a_short  = (r_rd.rec[1].held != 31'd0) && (r_price > 0);
                    end
                end
            end
            OP_LOAD: begin
                a_row.size = r_q;
            end
            default: begin
            end
        endcase
        a_row.rec[a_side] = a_rec;
    end

    // multiplier operand selection, 32x32 partial products
    logic [63:0]        m_a;
    logic [63:0]        m_b;
    logic               m_neg;
    logic signed [48:0] c_sel;
    logic signed [48:0] p_ext;
    logic signed [49:0] diff;
    logic [31:0]        a32;
    logic [31:0]        b32;
    logic [63:0]        m_pp;
    logic [127:0]       sh_pp;

    always_comb begin
        c_sel = r_row.rec[r_side].cost;
        p_ext = 49'(r_price);
        diff  = i_cmd.side ? (50'(r_row.rec[1].cost) - 50'(r_price))
                           : (50'(r_ask) - 50'(r_row.rec[0].cost));
        case (i_cmd.sel)
            MSEL_HCOST: begin
                m_a   = 64'(r_hold);
                m_b   = 64'(c_sel[48] ? -c_sel : c_sel);
                m_neg = c_sel[48];
            end
            MSEL_QPRICE: begin
                m_a   = 64'(r_q[30:0]);
                m_b   = 64'(p_ext[48] ? -p_ext : p_ext);
                m_neg = p_ext[48];
            end
            MSEL_HSIZE: begin
                m_a   = 64'(r_row.rec[i_cmd.side].held);
                m_b   = 64'(r_row.size[30:0]);
                m_neg = 1'b0;
            end
            default: begin
                m_a   = r_p1;
                m_b   = 64'(diff[49] ? -diff : diff);
                m_neg = diff[49];
            end
        endcase
        a32  = i_cmd.cnt[1] ? m_a[63:32] : m_a[31:0];
        b32  = i_cmd.cnt[0] ? m_b[63:32] : m_b[31:0];
        m_pp = a32 * b32;
        case (r_pps)
            2'd0:    sh_pp = {64'b0, r_pp};
            2'd1:    sh_pp = {32'b0, r_pp, 32'b0};
            default: sh_pp = {r_pp, 64'b0};
        endcase
    end

    logic signed [81:0] acc_s;
    logic signed [63:0] prof;
    logic signed [48:0] q_cost;
    assign acc_s  = r_neg ? -$signed(r_acc[81:0]) : $signed(r_acc[81:0]);
    assign q_cost = r_dneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    always_comb begin
        if (r_neg) begin
            prof = (r_acc >= 128'h8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000
                 : -$signed(r_acc[63:0]);
        end else begin
            prof = (r_acc > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF
                 : $signed(r_acc[63:0]);
        end
    end

    // two quotient bits per cycle
    logic [32:0] d33;
    logic [32:0] rem_a;
    logic [32:0] rem_a2;
    logic [32:0] rem_b;
    logic [32:0] rem_b2;
    logic        ge_a;
    logic        ge_b;
    always_comb begin
        d33    = {1'b0, r_dsr};
        rem_a  = {r_rem, r_dvd[81]};
        ge_a   = rem_a >= d33;
        rem_a2 = ge_a ? rem_a - d33 : rem_a;
        rem_b  = {rem_a2[31:0], r_dvd[80]};
        ge_b   = rem_b >= d33;
        rem_b2 = ge_b ? rem_b - d33 : rem_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_CLEAR) begin
            mem[r_clr] <= '0;
        end else if (i_cmd.op == CMD_WRITE) begin
            mem[addr] <= r_row;
        end
        if (i_cmd.op == CMD_READ) begin
            r_rd <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_need_div   <= 1'b0;
            r_need_long  <= 1'b0;
            r_need_short <= 1'b0;
        end else begin
            if (i_cmd.op == CMD_CLEAR) begin
                r_clr <= (r_clr == LAST_ADDR) ? '0 : r_clr + 1'b1;
            end
            if (i_cmd.op == CMD_APPLY) begin
                r_need_div   <= a_div;
                r_need_long  <= a_long;
                r_need_short <= a_short;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_LATCH: begin
                r_op    <= i_item.op;
                r_t     <= i_item.ticker;
                r_dir   <= i_item.direction;
                r_off   <= i_item.offset;
                r_q     <= i_item.quantity;
                r_price <= i_item.price;
                r_ask   <= i_item.ask_price;
            end
            CMD_MOD: begin
                if (mod_ge) r_t <= r_t - 10'(thr);
            end
            CMD_APPLY: begin
                r_row    <= a_row;
                r_status <= a_status;
                r_notify <= a_notify;
                r_side   <= a_side;
                r_hold   <= r_rd.rec[a_side].held;
                r_dsr    <= 32'(r_rd.rec[a_side].held) + 32'(r_q[30:0]);
            end
            CMD_MUL: begin
                if (i_cmd.cnt[2:0] == 3'd0) begin
                    r_acc <= '0;
                    r_neg <= m_neg;
                end else begin
                    r_acc <= r_acc + sh_pp;
                end
                if (i_cmd.cnt[2:0] != 3'd4) begin
                    r_pp  <= m_pp;
                    r_pps <= {1'b0, i_cmd.cnt[1]} + {1'b0, i_cmd.cnt[0]};
                end
            end
            CMD_NUM: begin
                if (i_cmd.cnt[0]) r_num <= r_num + acc_s;
                else              r_num <= acc_s;
            end
            CMD_DIVINIT: begin
                r_dvd  <= r_num[81] ? 82'(-r_num) : 82'(r_num);
                r_dneg <= r_num[81];
                r_rem  <= '0;
                r_quo  <= '0;
            end
            CMD_DIV: begin
                r_dvd <= {r_dvd[79:0], 2'b00};
                r_rem <= rem_b2[31:0];
                r_quo <= {r_quo[45:0], ge_a, ge_b};
            end
            CMD_COST: begin
                r_row.rec[r_side].cost <= q_cost;
            end
            CMD_P1: begin
                r_p1 <= r_acc[63:0];
            end
            CMD_PROFIT: begin
                r_row.rec[i_cmd.side].profit <= prof;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.clr_last   = r_clr == LAST_ADDR;
    assign o_sts.need_div   = r_need_div;
    assign o_sts.need_long  = r_need_long;
    assign o_sts.need_short = r_need_short;

    assign o_res.status            = r_status;
    assign o_res.notify            = r_notify;
    assign o_res.ticker_out        = r_t;
    assign o_res.side              = i_cmd.side;
    assign o_res.holdings_out      = r_row.rec[i_cmd.side].held;
    assign o_res.yesterday_out     = r_row.rec[i_cmd.side].yday;
    assign o_res.open_pending_out  = r_row.rec[i_cmd.side].openw;
    assign o_res.close_pending_out = r_row.rec[i_cmd.side].closew;
    assign o_res.cost_out          = r_row.rec[i_cmd.side].cost[47:0];
    assign o_res.profit_out        = r_row.rec[i_cmd.side].profit;
    assign o_res.last              = i_cmd.side;

endmodule

[rtl/core/plt_ctrl.sv]
// Ledger controller: sequences clearing, lookup, update, multiply, divide and result output.
module plt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  plt_pkg::t_sts i_sts,
    output plt_pkg::t_cmd o_cmd
);
    import plt_pkg::*;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_MOD   = 5'd2;
    localparam logic [4:0] S_READ  = 5'd3;
    localparam logic [4:0] S_APPLY = 5'd4;
    localparam logic [4:0] S_DISP  = 5'd5;
    localparam logic [4:0] S_MULA  = 5'd6;
    localparam logic [4:0] S_NUMA  = 5'd7;
    localparam logic [4:0] S_MULB  = 5'd8;
    localparam logic [4:0] S_NUMB  = 5'd9;
    localparam logic [4:0] S_DIVI  = 5'd10;
    localparam logic [4:0] S_DIV   = 5'd11;
    localparam logic [4:0] S_COST  = 5'd12;
    localparam logic [4:0] S_PMUL1 = 5'd13;
    localparam logic [4:0] S_P1    = 5'd14;
    localparam logic [4:0] S_PMUL2 = 5'd15;
    localparam logic [4:0] S_PROF  = 5'd16;
    localparam logic [4:0] S_WRITE = 5'd17;
    localparam logic [4:0] S_OUT0  = 5'd18;
    localparam logic [4:0] S_OUT1  = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [5:0] r_cnt;
    logic [5:0] n_cnt;
    logic       r_pside;
    logic       n_pside;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pside     = r_pside;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '{op: CMD_NONE, sel: MSEL_HCOST, cnt: r_cnt, side: r_pside};
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = CMD_CLEAR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = CMD_LATCH;
                    n_cnt    = MOD_LAST;
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.op = CMD_MOD;
                if (r_cnt == 6'd0) n_state = S_READ;
                else               n_cnt   = r_cnt - 6'd1;
            end
            S_READ: begin
                o_cmd.op = CMD_READ;
                n_state  = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.op = CMD_APPLY;
                n_state  = S_DISP;
            end
            S_DISP: begin
                n_cnt = 6'd0;
                if (i_sts.need_div) begin
                    n_state = S_MULA;
                end else if (i_sts.need_long) begin
                    n_pside = 1'b0;
                    n_state = S_PMUL1;
                end else if (i_sts.need_short) begin
                    n_pside = 1'b1;
                    n_state = S_PMUL1;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_MULA, S_MULB, S_PMUL1, S_PMUL2: begin
                o_cmd.op = CMD_MUL;
                case (r_state)
                    S_MULA:  o_cmd.sel = MSEL_HCOST;
                    S_MULB:  o_cmd.sel = MSEL_QPRICE;
                    S_PMUL1: o_cmd.sel = MSEL_HSIZE;
                    default: o_cmd.sel = MSEL_PDIFF;
                endcase
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == MUL_LAST) begin
                    n_cnt = 6'd0;
                    case (r_state)
                        S_MULA:  n_state = S_NUMA;
                        S_MULB:  n_state = S_NUMB;
                        S_PMUL1: n_state = S_P1;
                        default: n_state = S_PROF;
                    endcase
                end
            end
            S_NUMA: begin
                o_cmd.op  = CMD_NUM;
                o_cmd.cnt = 6'd0;
                n_state   = S_MULB;
            end
            S_NUMB: begin
                o_cmd.op  = CMD_NUM;
                o_cmd.cnt = 6'd1;
                n_state   = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.op = CMD_DIVINIT;
                n_cnt    = 6'd0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = CMD_DIV;
                n_cnt    = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) n_state = S_COST;
            end
            S_COST: begin
                o_cmd.op = CMD_COST;
                n_state  = S_WRITE;
            end
            S_P1: begin
                o_cmd.op = CMD_P1;
                n_cnt    = 6'd0;
                n_state  = S_PMUL2;
            end
            S_PROF: begin
                o_cmd.op = CMD_PROFIT;
                n_cnt    = 6'd0;
                if (!r_pside && i_sts.need_short) begin
                    n_pside = 1'b1;
                    n_state = S_PMUL1;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.op = CMD_WRITE;
                n_state  = S_OUT0;
            end
            S_OUT0: begin
                o_cmd.side  = 1'b0;
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_OUT1;
            end
            S_OUT1: begin
                o_cmd.side  = 1'b1;
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_pside <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pside <= n_pside;
        end
    end

endmodule

[rtl/core/position_ledger_table.sv]
// Position ledger table: per-instrument long/short records with average cost and profit.
// After reset the block walks the whole table once, one row per cycle, with the item
// channel not ready. Items are then handled one at a time: ticker reduction, row read and
// update, then the long and short records go out as two result transactions, long first,
// short marked last. A pending change, close fill, manual change or size load goes from the
// update straight to the row write and the output, which waits for result ready. An open
// fill adds two multiplies built from 32x32 partial products and a radix-4 divide for the
// new average cost. A profit update adds two such multiplies for each side it recomputes.
module position_ledger_table #(
    parameter int unsigned TICKERS = plt_pkg::TICKERS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    plt_in_if.sink     i_item,
    plt_out_if.source  o_result
);
    import plt_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_sts  sts;
    t_res  res;
    logic  in_ready;
    logic  out_valid;

    assign item.op        = i_item.op;
    assign item.ticker    = i_item.ticker;
    assign item.direction = i_item.direction;
    assign item.offset    = i_item.offset;
    assign item.quantity  = i_item.quantity;
    assign item.price     = i_item.price;
    assign item.ask_price = i_item.ask_price;

    plt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    plt_dp #(.TICKERS(TICKERS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (res)
    );

    assign i_item.ready               = in_ready;
    assign o_result.valid             = out_valid;
    assign o_result.status            = res.status;
    assign o_result.notify            = res.notify;
    assign o_result.ticker_out        = res.ticker_out;
    assign o_result.side              = res.side;
    assign o_result.holdings_out      = res.holdings_out;
    assign o_result.yesterday_out     = res.yesterday_out;
    assign o_result.open_pending_out  = res.open_pending_out;
    assign o_result.close_pending_out = res.close_pending_out;
    assign o_result.cost_out          = res.cost_out;
    assign o_result.profit_out        = res.profit_out;
    assign o_result.last              = res.last;

`ifndef SYNTH
    // one item at a time: never take an item while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_valid && in_ready))
        else $error("item channel ready while results pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && in_ready) |=> !in_ready)
        else $error("item channel still ready after a transaction");

    a_pair_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_result.ready && res.last) |=> (!out_valid && in_ready))
        else $error("block not idle after the short record");

    a_long_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_result.ready && !res.last) |=> (out_valid && res.last))
        else $error("short record does not follow the long record");
`endif

endmodule
